// ----- hdl/mmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpc_pkg
// Shared widths, codes and control types for the matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpc_pkg;

  // item field widths
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 3;
  localparam int VAL_W    = 32;
  localparam int PIX_W    = 8;
  localparam int RES_W    = 48;
  localparam int SIZE_W   = 4;
  localparam int MODE_W   = 2;
  localparam int CH_SEL_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // accumulators: up to 15 terms of a 64-bit product, and of a byte times Q16.16
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int CH_W   = 45;

  localparam int FRAC_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE    = 2'd2;

  // operand modes
  localparam logic [MODE_W-1:0] MODE_SCALAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT_PIX  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT_PIX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPERAND_MODE = 2'd3;

  // channel selects
  localparam logic [CH_SEL_W-1:0] CH_0 = 2'd0;
  localparam logic [CH_SEL_W-1:0] CH_1 = 2'd1;
  localparam logic [CH_SEL_W-1:0] CH_2 = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  localparam logic signed [RES_W-1:0] SAT_POS = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [RES_W-1:0] SAT_NEG = 48'sh8000_0000_0000;
  localparam logic [PIX_W-1:0]        PIX_MAX = 8'd255;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic                clear;
    logic                step;
    logic [CH_SEL_W-1:0] ch;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/mmpc_if.sv -----
// ----------------------------------------------------------------------------
// mmpc_if
// Valid/ready channels of the matrix multiply engine: request, response and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmpc_req_if;
  import mmpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] scalar_value;
  logic [PIX_W-1:0]        pixel_c0;
  logic [PIX_W-1:0]        pixel_c1;
  logic [PIX_W-1:0]        pixel_c2;

  modport source (output valid, kind, row, col, scalar_value, pixel_c0, pixel_c1, pixel_c2,
                  input ready);
  modport sink (input valid, kind, row, col, scalar_value, pixel_c0, pixel_c1, pixel_c2,
                output ready);
endinterface

interface mmpc_rsp_if;
  import mmpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] scalar_result;
  logic [PIX_W-1:0]        out_c0;
  logic [PIX_W-1:0]        out_c1;
  logic [PIX_W-1:0]        out_c2;
  logic                    index_error;

  modport source (output valid, scalar_result, out_c0, out_c1, out_c2, index_error,
                  input ready);
  modport sink (input valid, scalar_result, out_c0, out_c1, out_c2, index_error,
                output ready);
endinterface

interface mmpc_cfg_if;
  import mmpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/matrix_multiply_with_pixel_clamp.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_with_pixel_clamp
// Dense matrix multiply engine with Q16.16 saturation and pixel clamping.
// ----------------------------------------------------------------------------
// Load beats write one element of the left or right store; loads outside
// the configured sizes are dropped. A compute beat returns one result
// element (row, col) as the dot product over the inner dimension n, using a
// single 32x32 multiplier fed from the two stores, one multiply per term in
// scalar mode and one per term and channel in the color modes; no new beat
// is accepted until it finishes. An out-of-range request, which returns
// index_error, and a request with an empty inner dimension skip the
// multiplier. The finished result sits in an output register, so the next
// beat can be accepted while it waits. Stores read as undefined until
// written; the user must write configuration only while the block is idle;
// the block itself does not enforce it.
`default_nettype none

module matrix_multiply_with_pixel_clamp #(
  parameter int MAX_DIM = 8
) (
  input wire logic clk,
  input wire logic rst,
  mmpc_cfg_if.sink   cfg,
  mmpc_req_if.sink   req,
  mmpc_rsp_if.source rsp
);
  import mmpc_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EXT_W  = ADDR_W + 4;
  localparam int SC_W   = ACC_W - FRAC_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [SIZE_W-1:0] left_rows;
  logic [SIZE_W-1:0] inner_size;
  logic [SIZE_W-1:0] right_cols;
  logic [MODE_W-1:0] operand_mode;

  logic [SIZE_W-1:0] nr;
  logic [SIZE_W-1:0] nk;
  logic [SIZE_W-1:0] nc;
  logic [MODE_W-1:0] mode_eff;

  // sequencer
  logic [IDX_W-1:0]    row_q;
  logic [IDX_W-1:0]    col_q;
  logic [MODE_W-1:0]   mode_q;
  logic [SIZE_W-1:0]   nk_q;
  logic                err_q;
  logic [SIZE_W-1:0]   kk;
  logic [CH_SEL_W-1:0] ch;
  logic                s1_v;
  logic [CH_SEL_W-1:0] s1_ch;
  logic                last_ch;
  logic                last_step;

  logic req_fire;
  logic cmp_fire;
  logic in_range;

  // stores
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] left_raddr;
  logic [ADDR_W-1:0] right_raddr;
  logic [VAL_W-1:0]  pix_pack;
  logic              left_we;
  logic              right_we;
  logic [VAL_W-1:0]  left_wdata;
  logic [VAL_W-1:0]  right_wdata;
  logic [VAL_W-1:0]  left_rdata;
  logic [VAL_W-1:0]  right_rdata;

  // arithmetic
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] acc0;
  logic signed [CH_W-1:0]  acc1;
  logic signed [CH_W-1:0]  acc2;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] sc_round;
  logic signed [SC_W-1:0]  sc_int;
  logic signed [RES_W-1:0] sc_sat;

  // response register
  logic                    rsp_v;
  logic signed [RES_W-1:0] res_scalar;
  logic [PIX_W-1:0]        res_c0;
  logic [PIX_W-1:0]        res_c1;
  logic [PIX_W-1:0]        res_c2;
  logic                    res_err;
  logic                    rsp_load;

  // round half up to an integer, clamp to 0..255
  function automatic logic [PIX_W-1:0] clamp_px(input logic signed [CH_W-1:0] s);
    logic signed [CH_W-1:0]        t;
    logic signed [CH_W-FRAC_W-1:0] r;
    t = s + CH_W'(32768);
    r = t[CH_W-1:FRAC_W];
    if (r[CH_W-FRAC_W-1]) begin
      clamp_px = '0;
    end else if (|r[CH_W-FRAC_W-2:PIX_W]) begin
      clamp_px = PIX_MAX;
    end else begin
      clamp_px = r[PIX_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows    <= SIZE_RESET;
      inner_size   <= SIZE_RESET;
      right_cols   <= SIZE_RESET;
      operand_mode <= MODE_SCALAR;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LEFT_ROWS:    left_rows    <= cfg.data;
        REG_INNER_SIZE:   inner_size   <= cfg.data;
        REG_RIGHT_COLS:   right_cols   <= cfg.data;
        REG_OPERAND_MODE: operand_mode <= cfg.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign nr       = (32'(left_rows) < MAX_DIM)  ? left_rows  : SIZE_W'(MAX_DIM);
  assign nk       = (32'(inner_size) < MAX_DIM) ? inner_size : SIZE_W'(MAX_DIM);
  assign nc       = (32'(right_cols) < MAX_DIM) ? right_cols : SIZE_W'(MAX_DIM);
  assign mode_eff = (operand_mode == MODE_RESERVED) ? MODE_SCALAR : operand_mode;

  // ---------------------------------------------------------------- loads
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cmp_fire  = req_fire && (req.kind == KIND_COMPUTE);
  assign in_range  = ({1'b0, req.row} < nr) && ({1'b0, req.col} < nc);

  assign wr_addr  = ADDR_W'(EXT_W'(req.row) * EXT_W'(MAX_DIM) + EXT_W'(req.col));
  assign pix_pack = {{(VAL_W - 3 * PIX_W){1'b0}}, req.pixel_c2, req.pixel_c1, req.pixel_c0};

  assign left_we  = req_fire && (req.kind == KIND_LOAD_LEFT) &&
                    ({1'b0, req.row} < nr) && ({1'b0, req.col} < nk);
  assign right_we = req_fire && (req.kind == KIND_LOAD_RIGHT) &&
                    ({1'b0, req.row} < nk) && ({1'b0, req.col} < nc);
  assign left_wdata  = (mode_eff == MODE_LEFT_PIX)  ? pix_pack : req.scalar_value;
  assign right_wdata = (mode_eff == MODE_RIGHT_PIX) ? pix_pack : req.scalar_value;

  assign left_raddr  = ADDR_W'(EXT_W'(row_q) * EXT_W'(MAX_DIM) + EXT_W'(kk));
  assign right_raddr = ADDR_W'(EXT_W'(kk) * EXT_W'(MAX_DIM) + EXT_W'(col_q));

  mmpc_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_left_store (
    .clk   (clk),
    .we    (left_we),
    .waddr (wr_addr),
    .wdata (left_wdata),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  mmpc_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_right_store (
    .clk   (clk),
    .we    (right_we),
    .waddr (wr_addr),
    .wdata (right_wdata),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  // ------------------------------------------------------------- sequencer
  assign last_ch   = (mode_q == MODE_SCALAR) || (ch == CH_2);
  assign last_step = last_ch && (kk == nk_q - SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      s1_v  <= 1'b0;
    end else begin
      s1_v <= (state == S_RUN);
      case (state)
        S_IDLE: begin
          if (cmp_fire) begin
            if (!in_range || nk == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (last_step) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_v && !mac_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_ch <= ch;
    if (cmp_fire) begin
      row_q  <= req.row;
      col_q  <= req.col;
      mode_q <= mode_eff;
      nk_q   <= nk;
      err_q  <= !in_range;
      kk     <= '0;
      ch     <= CH_0;
    end else if (state == S_RUN) begin
      if (last_ch) begin
        ch <= CH_0;
        kk <= kk + SIZE_W'(1);
      end else begin
        ch <= ch + CH_SEL_W'(1);
      end
    end
  end

  assign mac_ctl.clear = cmp_fire;
  assign mac_ctl.step  = s1_v;
  assign mac_ctl.ch    = s1_ch;

  mmpc_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mac_ctl),
    .mode       (mode_q),
    .left_word  (left_rdata),
    .right_word (right_rdata),
    .acc0       (acc0),
    .acc1       (acc1),
    .acc2       (acc2),
    .busy       (mac_busy)
  );

  // ------------------------------------------------------------ finishing
  assign sc_round = acc0 + ACC_W'(32768);
  assign sc_int   = sc_round[ACC_W-1:FRAC_W];

  always_comb begin
    if ((&sc_int[SC_W-1:RES_W-1]) || !(|sc_int[SC_W-1:RES_W-1])) begin
      sc_sat = sc_int[RES_W-1:0];
    end else if (sc_int[SC_W-1]) begin
      sc_sat = SAT_NEG;
    end else begin
      sc_sat = SAT_POS;
    end
  end

  assign rsp_load = (state == S_DONE) && (!rsp_v || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_v <= 1'b0;
    end else if (rsp_load) begin
      rsp_v <= 1'b1;
    end else if (rsp.ready) begin
      rsp_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      res_err <= err_q;
      if (err_q) begin
        res_scalar <= '0;
        res_c0     <= '0;
        res_c1     <= '0;
        res_c2     <= '0;
      end else if (mode_q == MODE_SCALAR) begin
        res_scalar <= sc_sat;
        res_c0     <= '0;
        res_c1     <= '0;
        res_c2     <= '0;
      end else begin
        res_scalar <= '0;
        res_c0     <= clamp_px(CH_W'(acc0));
        res_c1     <= clamp_px(acc1);
        res_c2     <= clamp_px(acc2);
      end
    end
  end

  assign rsp.valid         = rsp_v;
  assign rsp.scalar_result = res_scalar;
  assign rsp.out_c0        = res_c0;
  assign rsp.out_c1        = res_c1;
  assign rsp.out_c2        = res_c2;
  assign rsp.index_error   = res_err;

  // ------------------------------------------------------------ assertions
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> kk < nk_q)
    else $error("term index past inner size");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> !s1_v && !mac_busy)
    else $error("result finished with terms still in flight");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!rsp.valid || rsp.ready) |=> rsp.valid && state == S_IDLE)
    else $error("finished result not registered");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.index_error |-> rsp.scalar_result == '0 && rsp.out_c0 == '0 &&
      rsp.out_c1 == '0 && rsp.out_c2 == '0)
    else $error("index error with nonzero result fields");

endmodule

`default_nettype wire

// ----- hdl/mmpc_ram.sv -----
// ----------------------------------------------------------------------------
// mmpc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/mmpc_mac.sv -----
// ----------------------------------------------------------------------------
// mmpc_mac
// Shared multiply-accumulate unit: picks the operands for one term, one
// registered 32x32 signed multiply, then adds into the selected accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpc_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire mmpc_pkg::mac_ctl_t                   ctl,
  input  wire logic [mmpc_pkg::MODE_W-1:0]          mode,
  input  wire logic [mmpc_pkg::VAL_W-1:0]           left_word,
  input  wire logic [mmpc_pkg::VAL_W-1:0]           right_word,
  output logic signed [mmpc_pkg::ACC_W-1:0]         acc0,
  output logic signed [mmpc_pkg::CH_W-1:0]          acc1,
  output logic signed [mmpc_pkg::CH_W-1:0]          acc2,
  output logic                                      busy
);
  import mmpc_pkg::*;

  logic [VAL_W-1:0]         pix_word;
  logic [PIX_W-1:0]         pix_byte;
  logic signed [VAL_W-1:0]  op_a;
  logic signed [VAL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  logic [CH_SEL_W-1:0]      prod_ch;
  logic signed [ACC_W-1:0]  acc_sel;
  logic signed [ACC_W-1:0]  acc_sum;

  always_comb begin
    pix_word = (mode == MODE_RIGHT_PIX) ? right_word : left_word;
    case (ctl.ch)
      CH_0:    pix_byte = pix_word[7:0];
      CH_1:    pix_byte = pix_word[15:8];
      CH_2:    pix_byte = pix_word[23:16];
      default: pix_byte = '0;
    endcase
    case (mode)
      MODE_LEFT_PIX: begin
        op_a = signed'({{(VAL_W-PIX_W){1'b0}}, pix_byte});
        op_b = signed'(right_word);
      end
      MODE_RIGHT_PIX: begin
        op_a = signed'({{(VAL_W-PIX_W){1'b0}}, pix_byte});
        op_b = signed'(left_word);
      end
      default: begin
        op_a = signed'(left_word);
        op_b = signed'(right_word);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod    <= op_a * op_b;
    prod_ch <= ctl.ch;
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.step;
    end
  end

  always_comb begin
    case (prod_ch)
      CH_1:    acc_sel = ACC_W'(acc1);
      CH_2:    acc_sel = ACC_W'(acc2);
      default: acc_sel = acc0;
    endcase
    acc_sum = acc_sel + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc0 <= '0;
      acc1 <= '0;
      acc2 <= '0;
    end else if (prod_v) begin
      case (prod_ch)
        CH_1:    acc1 <= CH_W'(acc_sum);
        CH_2:    acc2 <= CH_W'(acc_sum);
        default: acc0 <= acc_sum;
      endcase
    end
  end

  assign busy = prod_v;

endmodule

`default_nettype wire

// ----- test/matmul_checker.sv -----
// ----------------------------------------------------------------------------
// matmul_checker
// Watches the configuration, request and response channels of the matrix
// multiply engine. Keeps its own copy of both operand stores and of the size
// and mode registers, works out every requested result element as beats are
// accepted, and compares each response beat field by field, in order.
// ----------------------------------------------------------------------------
module matmul_checker #(
  parameter int MAX_DIM = 8
) (
  input wire logic clk,
  input wire logic rst,
  mmpc_cfg_if      cfg,
  mmpc_req_if      req,
  mmpc_rsp_if      rsp,
  output int       pending,
  output int       fail_count
);
  import mmpc_pkg::*;

  localparam int MAX_REPORTS = 100;
  localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_W - 1);

  typedef struct packed {
    logic signed [RES_W-1:0] scalar_result;
    logic [PIX_W-1:0]        c0;
    logic [PIX_W-1:0]        c1;
    logic [PIX_W-1:0]        c2;
    logic                    index_error;
  } elem_result_t;

  logic [VAL_W-1:0]  left_mem  [MAX_DIM*MAX_DIM];
  logic [VAL_W-1:0]  right_mem [MAX_DIM*MAX_DIM];
  logic [SIZE_W-1:0] rows_cfg;
  logic [SIZE_W-1:0] inner_cfg;
  logic [SIZE_W-1:0] cols_cfg;
  logic [MODE_W-1:0] mode_cfg;
  elem_result_t      results_due[$];
  int                rsp_count;

  initial begin
    fail_count = 0;
    pending    = 0;
    rsp_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int eff_size(input logic [SIZE_W-1:0] v);
    return (v < MAX_DIM) ? int'(v) : MAX_DIM;
  endfunction

  // mode 3 behaves as scalar
  function automatic logic [MODE_W-1:0] eff_mode();
    return (mode_cfg == MODE_RESERVED) ? MODE_SCALAR : mode_cfg;
  endfunction

  // round half up to an integer, then clamp to the pixel range
  function automatic logic [PIX_W-1:0] clamp_pixel(input logic signed [63:0] s);
    logic signed [63:0] r;
    r = (s + HALF_LSB) >>> FRAC_W;
    if (r < 0) return '0;
    if (r > $signed(64'(PIX_MAX))) return PIX_MAX;
    return r[PIX_W-1:0];
  endfunction

  function automatic elem_result_t dot_element(input int r, input int c);
    elem_result_t       res;
    logic [MODE_W-1:0]  m;
    logic signed [71:0] sum;
    logic signed [63:0] prod;
    logic signed [63:0] chan [3];
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] weight;
    logic [VAL_W-1:0]   pix;
    int                 nk;
    res = '0;
    nk  = eff_size(inner_cfg);
    m   = eff_mode();
    if (r >= eff_size(rows_cfg) || c >= eff_size(cols_cfg)) begin
      res.index_error = 1'b1;
      return res;
    end
    if (m == MODE_SCALAR) begin
      // exact Q32.32 sum, one rounding at the end, then saturate to 48 bits
      sum = '0;
      for (int k = 0; k < nk; k++) begin
        a    = left_mem[r*MAX_DIM + k];
        b    = right_mem[k*MAX_DIM + c];
        prod = a * b;
        sum += prod;
      end
      sum = (sum + HALF_LSB) >>> FRAC_W;
      if (sum > SAT_POS) res.scalar_result = SAT_POS;
      else if (sum < SAT_NEG) res.scalar_result = SAT_NEG;
      else res.scalar_result = sum[RES_W-1:0];
    end else begin
      foreach (chan[i]) chan[i] = '0;
      for (int k = 0; k < nk; k++) begin
        if (m == MODE_LEFT_PIX) begin
          pix    = left_mem[r*MAX_DIM + k];
          weight = right_mem[k*MAX_DIM + c];
        end else begin
          pix    = right_mem[k*MAX_DIM + c];
          weight = left_mem[r*MAX_DIM + k];
        end
        for (int ch = 0; ch < 3; ch++)
          chan[ch] += $signed({1'b0, pix[PIX_W*ch +: PIX_W]}) * weight;
      end
      res.c0 = clamp_pixel(chan[0]);
      res.c1 = clamp_pixel(chan[1]);
      res.c2 = clamp_pixel(chan[2]);
    end
    return res;
  endfunction

  task automatic apply_config();
    case (cfg.index)
      REG_LEFT_ROWS:    rows_cfg  = cfg.data;
      REG_INNER_SIZE:   inner_cfg = cfg.data;
      REG_RIGHT_COLS:   cols_cfg  = cfg.data;
      REG_OPERAND_MODE: mode_cfg  = cfg.data[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_request();
    int                nr;
    int                nk;
    int                nc;
    int                r;
    int                c;
    logic [MODE_W-1:0] m;
    logic [VAL_W-1:0]  pix_word;
    nr = eff_size(rows_cfg);
    nk = eff_size(inner_cfg);
    nc = eff_size(cols_cfg);
    m  = eff_mode();
    r  = req.row;
    c  = req.col;
    pix_word = {8'h00, req.pixel_c2, req.pixel_c1, req.pixel_c0};
    case (req.kind)
      KIND_LOAD_LEFT:
        if (r < nr && c < nk)
          left_mem[r*MAX_DIM + c] = (m == MODE_LEFT_PIX) ? pix_word : req.scalar_value;
      KIND_LOAD_RIGHT:
        if (r < nk && c < nc)
          right_mem[r*MAX_DIM + c] = (m == MODE_RIGHT_PIX) ? pix_word : req.scalar_value;
      KIND_COMPUTE:
        results_due.push_back(dot_element(r, c));
      default: ;  // unused kind: no effect
    endcase
  endtask

  task automatic check_field(input string name, input logic [RES_W-1:0] got,
                             input logic [RES_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                rsp_count, name, got, want));
  endtask

  task automatic check_response();
    elem_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing outstanding", rsp_count));
    end else begin
      want = results_due.pop_front();
      check_field("scalar_result", rsp.scalar_result, want.scalar_result);
      check_field("out_c0", rsp.out_c0, want.c0);
      check_field("out_c1", rsp.out_c1, want.c1);
      check_field("out_c2", rsp.out_c2, want.c2);
      check_field("index_error", rsp.index_error, want.index_error);
    end
    rsp_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_cfg  = SIZE_RESET;
      inner_cfg = SIZE_RESET;
      cols_cfg  = SIZE_RESET;
      mode_cfg  = MODE_SCALAR;
      results_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_response();
      if (cfg.valid && cfg.ready) apply_config();
      if (req.valid && req.ready) apply_request();
    end
    pending <= results_due.size();
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the matrix multiply engine: fills both stores, runs a short
// directed set (saturation, rounding tie, dropped loads, index errors, pixel
// clamping, zero and oversized dimensions, reserved mode), then random phases
// under several size and mode settings with sender idling, receiver stalls
// and one long receiver hold-off. Checking is done in matmul_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import mmpc_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int DIM           = 8;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 140;
  localparam int LIMIT_CYCLES  = 1_000_000;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   results_pending;

  int   idle_pct;
  int   stall_pct;
  int   hold_req;
  int   hold_ack;
  int   hold_left;
  int   rows_now;
  int   inner_now;
  int   cols_now;

  mmpc_cfg_if cfg_ch ();
  mmpc_req_if req_ch ();
  mmpc_rsp_if rsp_ch ();

  matrix_multiply_with_pixel_clamp #(.MAX_DIM(DIM)) u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  matmul_checker #(.MAX_DIM(DIM)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .pending    (results_pending),
    .fail_count (fail_count)
  );

  always #CLK_HALF clk = ~clk;

  // receiver: random stalls, plus a long hold-off when the stimulus asks
  initial begin
    rsp_ch.ready = 1'b0;
    hold_ack     = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        hold_ack     <= hold_req;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("status: fail");
    $finish;
  end

  function automatic logic [VAL_W-1:0] rand_scalar();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return VAL_W'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;  // within +-1.0
      // small weights keep pixel sums inside 0..255 often enough
      2: return VAL_W'($urandom_range(0, 32'h0000_2000));
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_8000;
        endcase
      end
      default: return -VAL_W'($urandom_range(0, 32'h0000_2000));
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [VAL_W-1:0] v,
                           input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1,
                           input logic [PIX_W-1:0] p2);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.row          <= r;
    req_ch.col          <= c;
    req_ch.scalar_value <= v;
    req_ch.pixel_c0     <= p0;
    req_ch.pixel_c1     <= p1;
    req_ch.pixel_c2     <= p2;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic load_scalar(input logic [KIND_W-1:0] kind, input int r, input int c,
                             input logic [VAL_W-1:0] v);
    send_item(kind, IDX_W'(r), IDX_W'(c), v, PIX_W'($urandom), PIX_W'($urandom),
              PIX_W'($urandom));
  endtask

  task automatic load_pixel(input logic [KIND_W-1:0] kind, input int r, input int c,
                            input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1,
                            input logic [PIX_W-1:0] p2);
    send_item(kind, IDX_W'(r), IDX_W'(c), $urandom(), p0, p1, p2);
  endtask

  task automatic request_elem(input int r, input int c);
    load_scalar(KIND_COMPUTE, r, c, $urandom());
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // registers change only with the engine idle; loads give no result, so settle
  task automatic set_config(input int lr, input int ik, input int rc,
                            input logic [MODE_W-1:0] m);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_LEFT_ROWS, CFG_DATA_W'(lr));
    write_reg(REG_INNER_SIZE, CFG_DATA_W'(ik));
    write_reg(REG_RIGHT_COLS, CFG_DATA_W'(rc));
    // upper data bits are don't-care for the mode register
    write_reg(REG_OPERAND_MODE, {(CFG_DATA_W - MODE_W)'($urandom), m});
    cfg_ch.valid <= 1'b0;
    rows_now  = lr;
    inner_now = ik;
    cols_now  = rc;
  endtask

  task automatic random_item();
    int                pick;
    int                rl;
    int                cl;
    int                nr;
    int                nk;
    int                nc;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    nr   = (rows_now < DIM) ? rows_now : DIM;
    nk   = (inner_now < DIM) ? inner_now : DIM;
    nc   = (cols_now < DIM) ? cols_now : DIM;
    pick = $urandom_range(0, 99);
    if (pick < 30) kind = KIND_LOAD_LEFT;
    else if (pick < 60) kind = KIND_LOAD_RIGHT;
    else if (pick < 96) kind = KIND_COMPUTE;
    else kind = KIND_UNUSED;
    case (kind)
      KIND_LOAD_LEFT: begin
        rl = nr;
        cl = nk;
      end
      KIND_LOAD_RIGHT: begin
        rl = nk;
        cl = nc;
      end
      default: begin
        rl = nr;
        cl = nc;
      end
    endcase
    // mostly in range; a tenth anywhere, which exercises drops and index errors
    if ($urandom_range(0, 9) == 0 || rl == 0 || cl == 0) begin
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
    end else begin
      r = IDX_W'($urandom_range(0, rl - 1));
      c = IDX_W'($urandom_range(0, cl - 1));
    end
    send_item(kind, r, c, rand_scalar(), PIX_W'($urandom), PIX_W'($urandom),
              PIX_W'($urandom));
  endtask

  task automatic run_phase(input int lr, input int ik, input int rc,
                           input logic [MODE_W-1:0] m, input int idle, input int stall,
                           input bit squeeze);
    set_config(lr, ik, rc, m);
    idle_pct   = idle;
    stall_pct <= stall;
    if (squeeze) hold_req <= hold_req + 1;
    repeat (PHASE_ITEMS) random_item();
  endtask

  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= KIND_LOAD_LEFT;
    req_ch.row          <= '0;
    req_ch.col          <= '0;
    req_ch.scalar_value <= '0;
    req_ch.pixel_c0     <= '0;
    req_ch.pixel_c1     <= '0;
    req_ch.pixel_c2     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_LEFT_ROWS;
    cfg_ch.data         <= '0;
    idle_pct             = 0;
    stall_pct           <= 0;
    hold_req            <= 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // write every entry once so no compute ever reads an unwritten one;
    // left row 0 and right columns 0/1 at the extremes for saturation
    set_config(DIM, DIM, DIM, MODE_SCALAR);
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        load_scalar(KIND_LOAD_LEFT, r, c, (r == 0) ? 32'h8000_0000 : rand_scalar());
        load_scalar(KIND_LOAD_RIGHT, r, c, (c == 0) ? 32'h8000_0000 :
                    (c == 1) ? 32'h7FFF_FFFF : rand_scalar());
      end
    end

    request_elem(0, 0);  // positive saturation
    request_elem(0, 1);  // negative saturation
    request_elem(DIM - 1, DIM - 1);
    load_scalar(KIND_UNUSED, 0, 0, $urandom());

    // loads outside the sizes are dropped, computes outside flag an error
    set_config(2, 1, 3, MODE_SCALAR);
    load_scalar(KIND_LOAD_LEFT, 2, 0, $urandom());
    load_scalar(KIND_LOAD_LEFT, 0, 1, $urandom());
    load_scalar(KIND_LOAD_RIGHT, 1, 0, $urandom());
    load_scalar(KIND_LOAD_RIGHT, 0, 3, $urandom());
    // -1 LSB times 0.5 lands exactly on a half: rounds up to zero
    load_scalar(KIND_LOAD_LEFT, 1, 0, 32'hFFFF_FFFF);
    load_scalar(KIND_LOAD_RIGHT, 0, 2, 32'h0000_8000);
    request_elem(1, 2);
    request_elem(2, 0);
    request_elem(0, 3);

    // left pixels: clamp high, half rounding, clamp low
    set_config(1, 2, 1, MODE_LEFT_PIX);
    load_pixel(KIND_LOAD_LEFT, 0, 0, 8'd255, 8'd0, 8'd128);
    load_pixel(KIND_LOAD_LEFT, 0, 1, 8'd255, 8'd255, 8'd0);
    load_scalar(KIND_LOAD_RIGHT, 0, 0, 32'h0001_0000);
    load_scalar(KIND_LOAD_RIGHT, 1, 0, 32'h0000_8000);
    request_elem(0, 0);
    load_scalar(KIND_LOAD_RIGHT, 1, 0, 32'hFFFF_0000);
    request_elem(0, 0);

    set_config(1, 1, 1, MODE_RIGHT_PIX);
    load_pixel(KIND_LOAD_RIGHT, 0, 0, 8'd1, 8'd2, 8'd3);
    load_scalar(KIND_LOAD_LEFT, 0, 0, 32'h7FFF_FFFF);
    request_elem(0, 0);

    // oversized rows and cols, empty inner dimension, reserved mode
    set_config(15, 0, 9, MODE_RESERVED);
    load_scalar(KIND_LOAD_LEFT, 0, 0, $urandom());
    load_scalar(KIND_LOAD_RIGHT, 0, 0, $urandom());
    request_elem(DIM - 1, DIM - 1);

    set_config(0, DIM, DIM, MODE_SCALAR);
    request_elem(0, 0);

    run_phase(8, 8, 8, MODE_SCALAR, 0, 0, 1'b0);
    run_phase(8, 8, 8, MODE_LEFT_PIX, 78, 0, 1'b0);
    run_phase(8, 8, 8, MODE_RIGHT_PIX, 0, 78, 1'b1);
    run_phase(3, 5, 2, MODE_SCALAR, 19, 19, 1'b0);
    run_phase(1, 1, 1, MODE_LEFT_PIX, 0, 0, 1'b0);
    run_phase(15, 8, 12, MODE_RIGHT_PIX, 78, 0, 1'b0);
    run_phase(5, 3, 7, MODE_RESERVED, 0, 78, 1'b0);
    run_phase(8, 1, 8, MODE_SCALAR, 19, 19, 1'b0);

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
